[rtl/otsu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// otsu_pkg
// shared constants, operation codes and control structs of the otsu threshold
// block
// ----------------------------------------------------------------------------
package otsu_pkg;

	localparam int BINS_DEF       = 256;
	localparam int COUNT_BITS_DEF = 24;

	localparam int DATA_W   = 24;
	localparam int PC_W     = 24;
	localparam int LVL_W    = 8;
	localparam int SUM_W    = 32;
	localparam int LIMB_W   = 32;
	localparam int MUL_W    = 64;
	localparam int AB_W     = 56;
	localparam int PROD_W   = 48;
	localparam int SQ_W     = 112;
	localparam int ACC_W    = 192;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [PADDR_W-1:0] ADDR_PIXEL_COUNT = 3'd0;

	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_TOT  = 4'd1;
	localparam logic [3:0] OP_SB   = 4'd2;
	localparam logic [3:0] OP_A    = 4'd3;
	localparam logic [3:0] OP_B    = 4'd4;
	localparam logic [3:0] OP_P    = 4'd5;
	localparam logic [3:0] OP_SQ   = 4'd6;
	localparam logic [3:0] OP_L    = 4'd7;
	localparam logic [3:0] OP_R    = 4'd8;

	typedef struct packed {
		logic [3:0] op;
		logic [2:0] k;
		logic       load;
		logic       scan_init;
		logic       rd;
		logic       bin_add;
		logic       idx_inc;
		logic       mag_ld;
		logic       acc_clr;
		logic       sq_ld;
		logic       lhs_ld;
		logic       decide;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic room;
		logic more;
		logic bc_zero;
		logic bc_ge_pc;
		logic take;
		logic out_full;
	} sts_t;

endpackage
`default_nettype wire

[rtl/otsu_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// otsu_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module otsu_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/otsu_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// otsu_ctrl
// sequencer for histogram loading and the per bin scoring scan
// ----------------------------------------------------------------------------
module otsu_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	input  wire logic          s_tlast,
	output logic               s_tready,
	output otsu_pkg::cmd_t     cmd,
	input  wire otsu_pkg::sts_t sts
);
	import otsu_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_RD   = 5'd1;
	localparam logic [4:0] S_H    = 5'd2;
	localparam logic [4:0] S_SBW  = 5'd3;
	localparam logic [4:0] S_CHK  = 5'd4;
	localparam logic [4:0] S_MB   = 5'd5;
	localparam logic [4:0] S_MP   = 5'd6;
	localparam logic [4:0] S_PW   = 5'd7;
	localparam logic [4:0] S_SQ   = 5'd8;
	localparam logic [4:0] S_D1   = 5'd9;
	localparam logic [4:0] S_LQ   = 5'd10;
	localparam logic [4:0] S_L    = 5'd11;
	localparam logic [4:0] S_D2   = 5'd12;
	localparam logic [4:0] S_LL   = 5'd13;
	localparam logic [4:0] S_R    = 5'd14;
	localparam logic [4:0] S_D3   = 5'd15;
	localparam logic [4:0] S_DEC  = 5'd16;
	localparam logic [4:0] S_FIN  = 5'd17;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic [2:0] k_q;
	logic       rdy;

	assign rdy      = (state_q == S_IDLE) && !(sts.out_full && s_tlast);
	assign s_tready = rdy;

	always_comb begin
		cmd     = '0;
		cmd.k   = k_q;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid && rdy) begin
					cmd.load = 1'b1;
					if (sts.room) begin
						cmd.op = OP_TOT;
					end
					if (s_tlast) begin
						cmd.scan_init = 1'b1;
						state_d       = S_RD;
					end
				end
			end
			S_RD: begin
				if (!sts.more) begin
					state_d = S_FIN;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_H;
				end
			end
			S_H: begin
				cmd.bin_add = 1'b1;
				cmd.op      = OP_SB;
				state_d     = S_SBW;
			end
			S_SBW: begin
				if (sts.bc_zero) begin
					cmd.idx_inc = 1'b1;
					state_d     = S_RD;
				end else if (sts.bc_ge_pc) begin
					state_d = S_FIN;
				end else begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				cmd.op  = OP_A;
				state_d = S_MB;
			end
			S_MB: begin
				cmd.op  = OP_B;
				state_d = S_MP;
			end
			S_MP: begin
				cmd.op  = OP_P;
				state_d = S_PW;
			end
			S_PW: begin
				cmd.mag_ld = 1'b1;
				state_d    = S_SQ;
			end
			S_SQ: begin
				cmd.op = OP_SQ;
				if (k_q == 3'd3) begin
					state_d = S_D1;
				end
			end
			S_D1: begin
				state_d = S_LQ;
			end
			S_LQ: begin
				cmd.sq_ld   = 1'b1;
				cmd.acc_clr = 1'b1;
				state_d     = S_L;
			end
			S_L: begin
				cmd.op = OP_L;
				if (k_q == 3'd7) begin
					state_d = S_D2;
				end
			end
			S_D2: begin
				state_d = S_LL;
			end
			S_LL: begin
				cmd.lhs_ld  = 1'b1;
				cmd.acc_clr = 1'b1;
				state_d     = S_R;
			end
			S_R: begin
				cmd.op = OP_R;
				if (k_q == 3'd7) begin
					state_d = S_D3;
				end
			end
			S_D3: begin
				state_d = S_DEC;
			end
			S_DEC: begin
				cmd.decide  = 1'b1;
				cmd.acc_clr = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = S_RD;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= (state_d != state_q) ? 3'd0 : k_q + 3'd1;
		end
	end

endmodule
`default_nettype wire

[rtl/otsu_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// otsu_dp
// bin store, accumulators, shared 32x32 multiplier with limb accumulator and
// exact score compare
// ----------------------------------------------------------------------------
module otsu_dp #(
	parameter int BINS       = 256,
	parameter int COUNT_BITS = 24
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire otsu_pkg::cmd_t               cmd,
	output otsu_pkg::sts_t                    sts,
	input  wire logic [otsu_pkg::DATA_W-1:0]  bin_count,
	input  wire logic [otsu_pkg::PC_W-1:0]    pc,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic      [otsu_pkg::LVL_W-1:0]   threshold
);
	import otsu_pkg::*;

	localparam int IDXW = $clog2(BINS);
	localparam int CNTW = IDXW + 1;
	localparam int BCW  = COUNT_BITS + 1;
	localparam int CMPW = (BCW > PC_W) ? BCW : PC_W;

	logic [CNTW-1:0]       load_idx_q;
	logic [CNTW-1:0]       scan_idx_q;
	logic [SUM_W-1:0]      total_q;
	logic [SUM_W-1:0]      sb_q;
	logic [BCW-1:0]        bc_q;
	logic [COUNT_BITS-1:0] count_w;
	logic [COUNT_BITS-1:0] h;
	logic                  we;
	logic [3:0]            op_s1;
	logic [2:0]            off_s1;
	logic [MUL_W-1:0]      p_s1;
	logic [AB_W-1:0]       a_q;
	logic [AB_W-1:0]       b_q;
	logic [AB_W-1:0]       mag_q;
	logic [AB_W-1:0]       mag;
	logic [PROD_W-1:0]     prod_q;
	logic [ACC_W-1:0]      acc_q;
	logic [SQ_W-1:0]       sq_q;
	logic [ACC_W-1:0]      lhs_q;
	logic [SQ_W-1:0]       bsq_q;
	logic [PROD_W-1:0]     bprod_q;
	logic [IDXW-1:0]       blvl_q;
	logic [PC_W-1:0]       wf;
	logic [LIMB_W-1:0]     x;
	logic [LIMB_W-1:0]     y;
	logic [2:0]            off;
	logic [MUL_W-1:0]      mag64;
	logic [MUL_W-1:0]      bprod64;
	logic [MUL_W-1:0]      prod64;
	logic [127:0]          sq128;
	logic [127:0]          bsq128;

	assign count_w = COUNT_BITS'(bin_count);
	assign we      = cmd.load && sts.room;
	assign mag     = (a_q >= b_q) ? (a_q - b_q) : (b_q - a_q);
	assign wf      = pc - PC_W'(bc_q);
	assign mag64   = MUL_W'(mag_q);
	assign bprod64 = MUL_W'(bprod_q);
	assign prod64  = MUL_W'(prod_q);
	assign sq128   = 128'(sq_q);
	assign bsq128  = 128'(bsq_q);

	assign sts.room     = load_idx_q < CNTW'(BINS);
	assign sts.more     = scan_idx_q < load_idx_q;
	assign sts.bc_zero  = (bc_q == '0);
	assign sts.bc_ge_pc = CMPW'(bc_q) >= CMPW'(pc);
	assign sts.take     = lhs_q >= acc_q;
	assign sts.out_full = m_tvalid;

	otsu_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(BINS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(load_idx_q[IDXW-1:0]),
		.wdata(count_w),
		.re   (cmd.rd),
		.raddr(scan_idx_q[IDXW-1:0]),
		.rdata(h)
	);

	always_comb begin
		x   = '0;
		y   = '0;
		off = '0;
		case (cmd.op)
			OP_TOT: begin
				x = LIMB_W'(load_idx_q);
				y = LIMB_W'(count_w);
			end
			OP_SB: begin
				x = LIMB_W'(scan_idx_q);
				y = LIMB_W'(h);
			end
			OP_A: begin
				x = sb_q;
				y = LIMB_W'(pc);
			end
			OP_B: begin
				x = total_q;
				y = LIMB_W'(bc_q);
			end
			OP_P: begin
				x = LIMB_W'(bc_q);
				y = LIMB_W'(wf);
			end
			OP_SQ: begin
				x   = mag64[{cmd.k[0], 5'd0} +: LIMB_W];
				y   = mag64[{cmd.k[1], 5'd0} +: LIMB_W];
				off = 3'(cmd.k[0]) + 3'(cmd.k[1]);
			end
			OP_L: begin
				x   = sq128[{cmd.k[1:0], 5'd0} +: LIMB_W];
				y   = bprod64[{cmd.k[2], 5'd0} +: LIMB_W];
				off = 3'(cmd.k[1:0]) + 3'(cmd.k[2]);
			end
			OP_R: begin
				x   = bsq128[{cmd.k[1:0], 5'd0} +: LIMB_W];
				y   = prod64[{cmd.k[2], 5'd0} +: LIMB_W];
				off = 3'(cmd.k[1:0]) + 3'(cmd.k[2]);
			end
			default: begin
				x = '0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_idx_q <= '0;
			scan_idx_q <= '0;
			total_q    <= '0;
			op_s1      <= OP_NONE;
			m_tvalid   <= 1'b0;
		end else begin
			op_s1 <= cmd.op;
			if (op_s1 == OP_TOT) begin
				total_q <= total_q + p_s1[SUM_W-1:0];
			end
			if (we) begin
				load_idx_q <= load_idx_q + CNTW'(1);
			end
			if (cmd.scan_init) begin
				scan_idx_q <= '0;
			end else if (cmd.idx_inc) begin
				scan_idx_q <= scan_idx_q + CNTW'(1);
			end
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (cmd.finish) begin
				load_idx_q <= '0;
				total_q    <= '0;
				m_tvalid   <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		off_s1 <= off;
		p_s1   <= MUL_W'(x) * MUL_W'(y);
		case (op_s1) inside
			OP_SB: sb_q <= sb_q + p_s1[SUM_W-1:0];
			OP_A: a_q <= p_s1[AB_W-1:0];
			OP_B: b_q <= p_s1[AB_W-1:0];
			OP_P: prod_q <= p_s1[PROD_W-1:0];
			OP_SQ, OP_L, OP_R: acc_q <= acc_q + (ACC_W'(p_s1) << {off_s1, 5'd0});
			default: begin
			end
		endcase
		if (cmd.bin_add) begin
			bc_q <= bc_q + BCW'(h);
		end
		if (cmd.mag_ld) begin
			mag_q <= mag;
		end
		if (cmd.sq_ld) begin
			sq_q <= acc_q[SQ_W-1:0];
		end
		if (cmd.lhs_ld) begin
			lhs_q <= acc_q;
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end
		if (cmd.decide && sts.take) begin
			bsq_q   <= sq_q;
			bprod_q <= prod_q;
			blvl_q  <= scan_idx_q[IDXW-1:0];
		end
		if (cmd.scan_init) begin
			bc_q    <= '0;
			sb_q    <= '0;
			acc_q   <= '0;
			bsq_q   <= '0;
			bprod_q <= PROD_W'(1);
			blvl_q  <= '0;
		end
		if (cmd.finish) begin
			threshold <= LVL_W'(blvl_q);
		end
	end

endmodule
`default_nettype wire

[rtl/otsu_threshold_select.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// otsu_threshold_select
// otsu threshold over a gray-level histogram, exact integer score compare
// ----------------------------------------------------------------------------
// usage:
//   write pixel_count at apb address 0 while the block is idle (reset value 1)
//   stream the histogram on s_*, one bin count per transfer in bin order,
//   s_tlast on the final bin; loading takes one transfer per cycle
//   bins past BINS are dropped, s_tlast on such a transfer still starts a scan
//   after the last bin the block scans the stored bins with one shared 32x32
//   multiplier, skipping the scoring of bins while the background is empty;
//   s_tready is low during the scan
//   the threshold is held in an output register on m_* until taken; new bins
//   are accepted meanwhile, only a final bin waits for the register to drain
//   reset clears the load counter, the weighted sum and the output valid;
//   the bin store needs no clearing
// ----------------------------------------------------------------------------
module otsu_threshold_select #(
	parameter int BINS       = otsu_pkg::BINS_DEF,
	parameter int COUNT_BITS = otsu_pkg::COUNT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [otsu_pkg::DATA_W-1:0]   s_tdata,   // bin_count
	input  wire logic                          s_tlast,   // last_bin
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [otsu_pkg::LVL_W-1:0]    m_tdata,   // threshold
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [otsu_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [otsu_pkg::PDATA_W-1:0]  pwdata,
	output logic      [otsu_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready
);
	import otsu_pkg::*;

	logic [PC_W-1:0] pc_q;
	cmd_t            cmd;
	sts_t            sts;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_PIXEL_COUNT) ? PDATA_W'(pc_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_W'(1);
		end else if (psel && penable && pwrite && pready && paddr == ADDR_PIXEL_COUNT) begin
			pc_q <= pwdata[PC_W-1:0];
		end
	end

	otsu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tlast (s_tlast),
		.s_tready(s_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	otsu_dp #(
		.BINS      (BINS),
		.COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.bin_count(s_tdata),
		.pc       (pc_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.threshold(m_tdata)
	);

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input accepted right after the last bin");

	a_result_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result raised outside a scan");

	a_last_waits: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && s_tlast |-> !s_tready)
		else $error("last bin accepted while a result is pending");

endmodule
`default_nettype wire
